>>> design/lpp_pkg.sv
// Package for the lidar point label projector.
// Holds map geometry, divider sizing, register and request codes and the shared item types.
// No dependencies.
`timescale 1ns / 1ps

package lpp_pkg;

    localparam int IMG_W     = 1024;
    localparam int IMG_H     = 512;
    localparam int MAP_DEPTH = IMG_W * IMG_H;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int COL_W     = $clog2(IMG_W);
    localparam int ROW_W     = $clog2(IMG_H);

    // quotient bits kept by the divider; larger quotients raise overflow
    localparam int DIV_QW  = 34;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_LATERAL = 3'd0;
    localparam logic [2:0] REG_FWD_MIN = 3'd1;
    localparam logic [2:0] REG_FWD_MAX = 3'd2;
    localparam logic [2:0] REG_DEP_MIN = 3'd3;
    localparam logic [2:0] REG_DEP_MAX = 3'd4;
    localparam logic [2:0] REG_MODE    = 3'd5;

    localparam logic [30:0] LATERAL_RST = 31'd655360;
    localparam logic [31:0] FWD_MIN_RST = 32'd0;
    localparam logic [31:0] FWD_MAX_RST = 32'd1966080;
    localparam logic [31:0] DEP_MIN_RST = 32'd0;
    localparam logic [31:0] DEP_MAX_RST = 32'd1966080;

    localparam logic [1:0] REQ_POINT = 2'd0;
    localparam logic [1:0] REQ_LABEL = 2'd1;
    localparam logic [1:0] REQ_CALIB = 2'd2;

    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_THREE = 2'd1;
    localparam logic [1:0] MODE_TWO   = 2'd2;
    localparam logic [1:0] MODE_OFF   = 2'd3;

    localparam int         CAL_MAT_N = 12;
    localparam logic [3:0] CAL_FX    = 4'd12;
    localparam logic [3:0] CAL_FY    = 4'd13;
    localparam logic [3:0] CAL_CX    = 4'd14;
    localparam logic [3:0] CAL_CY    = 4'd15;

    localparam logic [7:0] LBL_YELLOW = 8'd1;
    localparam logic [7:0] LBL_BLUE   = 8'd2;
    localparam logic [7:0] LBL_RED    = 8'd3;
    localparam logic [7:0] LBL_NONE   = 8'd0;

    localparam logic [7:0] COLOR_FULL = 8'd255;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_POINT,
        OP_LABEL,
        OP_CALIB
    } op_t;

    // point: px/py/pz coordinates; label: px map address, py value; calib: px value, py index
    typedef struct packed {
        op_t         op;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  dok;
        logic  u_neg;
        logic  v_neg;
    } side_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

>>> design/lpp_stream_if.sv
// Stream interfaces of the lidar point label projector: input items and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface lpp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [9:0]         pixel_col;
    logic [8:0]         pixel_row;
    logic [7:0]         label_value;
    logic [3:0]         calib_index;
    logic signed [31:0] calib_value;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, pixel_col, pixel_row,
               label_value, calib_index, calib_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, pixel_col, pixel_row,
               label_value, calib_index, calib_value,
        output ready
    );
endinterface

interface lpp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    modport source (
        output valid, out_x, out_y, out_z, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, red, green, blue,
        output ready
    );
endinterface

>>> design/lpp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lpp_div.sv
// Pipelined restoring divider, one quotient bit per stage after the entry stage, unsigned magnitudes.
// Depends on lpp_pkg.
`timescale 1ns / 1ps

module lpp_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [63:0]                 num,
    input  logic [31:0]                 den,
    output logic [lpp_pkg::DIV_QW-1:0]  quo,
    output logic                        ovf
);

    logic [31:0]                rem_reg  [lpp_pkg::DIV_LAT];
    logic [lpp_pkg::DIV_QW-1:0] low_reg  [lpp_pkg::DIV_LAT];
    logic [lpp_pkg::DIV_QW-1:0] quo_reg  [lpp_pkg::DIV_LAT];
    logic [31:0]                den_reg  [lpp_pkg::DIV_LAT];
    logic                       ovf_reg  [lpp_pkg::DIV_LAT];

    logic [31:0]                rem_next [lpp_pkg::DIV_LAT];
    logic [lpp_pkg::DIV_QW-1:0] quo_next [lpp_pkg::DIV_LAT];

    always_comb
    begin
        logic [32:0] trial;
        logic        ge;
        rem_next[0] = 32'(num[63:lpp_pkg::DIV_QW]);
        quo_next[0] = '0;
        for (int k = 1; k < lpp_pkg::DIV_LAT; k++)
        begin
            trial       = {rem_reg[k-1], low_reg[k-1][lpp_pkg::DIV_QW-k]};
            ge          = trial >= {1'b0, den_reg[k-1]};
            rem_next[k] = ge ? 32'(trial - {1'b0, den_reg[k-1]}) : trial[31:0];
            quo_next[k] = quo_reg[k-1];
            quo_next[k][lpp_pkg::DIV_QW-k] = ge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            low_reg[0] <= num[lpp_pkg::DIV_QW-1:0];
            den_reg[0] <= den;
            ovf_reg[0] <= 32'(num[63:lpp_pkg::DIV_QW]) >= den;
            for (int k = 0; k < lpp_pkg::DIV_LAT; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k < lpp_pkg::DIV_LAT; k++)
            begin
                low_reg[k] <= low_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[lpp_pkg::DIV_LAT-1];
    assign ovf = ovf_reg[lpp_pkg::DIV_LAT-1];

endmodule

>>> design/lidar_point_label_projector.sv
// Top level of the lidar point label projector: filter, transform, project, label lookup.
// Depends on lpp_pkg, lpp_stream_if, lpp_ram and lpp_div.
//
//   channel    role    handshake        carries
//   item_in    sink    valid/ready      point, label write or calibration write
//   item_out   source  valid/ready      original point and its colour
//   APB        slave   psel/penable     six configuration registers
//
// One item per cycle while no waiting result holds the pipeline.
// The 35-stage divider turns the projection into pixels.
// All stages advance together; a waiting result in the output register freezes them.
// Reset clears valid bits and configuration; the label map and calibration start unknown.
`timescale 1ns / 1ps

module lidar_point_label_projector (
    input  logic                        clk,
    input  logic                        rst_n,
    lpp_in_if.sink                      item_in,
    lpp_out_if.source                   item_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpp_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
    localparam logic signed [49:0] SAT_LO = -50'sd2147483648;
    localparam logic signed [35:0] PIX_LO = -36'sd65536;
    localparam logic signed [35:0] U_HI   = 36'(lpp_pkg::IMG_W * 65536);
    localparam logic signed [35:0] V_HI   = 36'(lpp_pkg::IMG_H * 65536);

    // configuration
    logic [30:0]        lateral_reg;
    logic signed [31:0] fmin_reg;
    logic signed [31:0] fmax_reg;
    logic signed [31:0] dmin_reg;
    logic signed [31:0] dmax_reg;
    logic [1:0]         mode_reg;
    logic [2:0]         cfg_idx;

    assign cfg_idx = paddr[lpp_pkg::CFG_AW-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lateral_reg <= lpp_pkg::LATERAL_RST;
            fmin_reg    <= lpp_pkg::FWD_MIN_RST;
            fmax_reg    <= lpp_pkg::FWD_MAX_RST;
            dmin_reg    <= lpp_pkg::DEP_MIN_RST;
            dmax_reg    <= lpp_pkg::DEP_MAX_RST;
            mode_reg    <= lpp_pkg::MODE_ALL;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                lpp_pkg::REG_LATERAL: lateral_reg <= pwdata[30:0];
                lpp_pkg::REG_FWD_MIN: fmin_reg    <= pwdata;
                lpp_pkg::REG_FWD_MAX: fmax_reg    <= pwdata;
                lpp_pkg::REG_DEP_MIN: dmin_reg    <= pwdata;
                lpp_pkg::REG_DEP_MAX: dmax_reg    <= pwdata;
                lpp_pkg::REG_MODE:    mode_reg    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lpp_pkg::REG_LATERAL: prdata = {1'b0, lateral_reg};
            lpp_pkg::REG_FWD_MIN: prdata = fmin_reg;
            lpp_pkg::REG_FWD_MAX: prdata = fmax_reg;
            lpp_pkg::REG_DEP_MIN: prdata = dmin_reg;
            lpp_pkg::REG_DEP_MAX: prdata = dmax_reg;
            lpp_pkg::REG_MODE:    prdata = {30'd0, mode_reg};
            default:              prdata = '0;
        endcase
    end

    // flow control
    logic adv;
    logic acc;
    logic out_vld_reg;

    assign adv           = !out_vld_reg || item_out.ready;
    assign acc           = item_in.valid && adv;
    assign item_in.ready = adv;

    // entry decode
    lpp_pkg::item_t     in_item_next;
    logic signed [32:0] py33;
    logic signed [32:0] lim33;
    logic               lat_ok;
    logic               fwd_ok;
    logic               in_map;
    logic [31:0]        map_addr;

    assign py33     = {item_in.pos_y[31], item_in.pos_y};
    assign lim33    = {2'b00, lateral_reg};
    assign lat_ok   = (py33 <= lim33) && (py33 >= -lim33);
    assign fwd_ok   = (item_in.pos_x >= fmin_reg) && (item_in.pos_x <= fmax_reg);
    assign in_map   = (32'(item_in.pixel_col) < 32'(lpp_pkg::IMG_W))
                   && (32'(item_in.pixel_row) < 32'(lpp_pkg::IMG_H));
    assign map_addr = 32'(item_in.pixel_row) * 32'(lpp_pkg::IMG_W)
                    + 32'(item_in.pixel_col);

    always_comb
    begin
        in_item_next.op = lpp_pkg::OP_NONE;
        in_item_next.px = item_in.pos_x;
        in_item_next.py = item_in.pos_y;
        in_item_next.pz = item_in.pos_z;
        case (item_in.req_type)
            lpp_pkg::REQ_POINT:
            begin
                if (lat_ok && fwd_ok)
                begin
                    in_item_next.op = lpp_pkg::OP_POINT;
                end
            end
            lpp_pkg::REQ_LABEL:
            begin
                if (in_map)
                begin
                    in_item_next.op = lpp_pkg::OP_LABEL;
                end
                in_item_next.px = map_addr;
                in_item_next.py = {24'd0, item_in.label_value};
            end
            lpp_pkg::REQ_CALIB:
            begin
                in_item_next.op = lpp_pkg::OP_CALIB;
                in_item_next.px = item_in.calib_value;
                in_item_next.py = {28'd0, item_in.calib_index};
            end
            default: ;
        endcase
    end

    // stage 1: matrix products
    logic               st1_vld_reg;
    lpp_pkg::item_t     st1_item_reg;
    logic signed [31:0] mat_reg [lpp_pkg::CAL_MAT_N];
    logic signed [31:0] pt1 [3];
    logic [3:0]         idx1;
    logic signed [63:0] prod_next [9];
    logic signed [31:0] trans_next [3];

    assign pt1[0] = st1_item_reg.px;
    assign pt1[1] = st1_item_reg.py;
    assign pt1[2] = st1_item_reg.pz;
    assign idx1   = st1_item_reg.py[3:0];

    always_ff @(posedge clk)
    begin
        if (adv && st1_vld_reg && st1_item_reg.op == lpp_pkg::OP_CALIB
            && idx1 < 4'(lpp_pkg::CAL_MAT_N))
        begin
            mat_reg[idx1] <= st1_item_reg.px;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r*3+c] = 64'(mat_reg[r*4+c]) * 64'(pt1[c]);
            end
            trans_next[r] = mat_reg[r*4+3];
        end
    end

    // stage 2: floor, sum and saturate
    logic               st2_vld_reg;
    lpp_pkg::item_t     st2_item_reg;
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] trans_reg [3];
    logic signed [31:0] xf_next [3];

    always_comb
    begin
        logic signed [49:0] sum_v;
        for (int r = 0; r < 3; r++)
        begin
            sum_v = 50'(prod_reg[r*3] >>> 16) + 50'(prod_reg[r*3+1] >>> 16)
                  + 50'(prod_reg[r*3+2] >>> 16) + 50'(trans_reg[r]);
            if (sum_v > SAT_HI)
            begin
                xf_next[r] = 32'sh7fffffff;
            end
            else if (sum_v < SAT_LO)
            begin
                xf_next[r] = 32'sh80000000;
            end
            else
            begin
                xf_next[r] = sum_v[31:0];
            end
        end
    end

    // stage 3: depth window, magnitudes and signs
    logic               st3_vld_reg;
    lpp_pkg::item_t     st3_item_reg;
    logic signed [31:0] xf_reg [3];
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic [3:0]         idx3;
    lpp_pkg::side_t     side4_next;

    assign idx3 = st3_item_reg.py[3:0];

    always_ff @(posedge clk)
    begin
        if (adv && st3_vld_reg && st3_item_reg.op == lpp_pkg::OP_CALIB)
        begin
            if (idx3 == lpp_pkg::CAL_FX)
            begin
                fx_reg <= st3_item_reg.px;
            end
            if (idx3 == lpp_pkg::CAL_FY)
            begin
                fy_reg <= st3_item_reg.px;
            end
        end
    end

    always_comb
    begin
        side4_next.item  = st3_item_reg;
        side4_next.dok   = (xf_reg[1] != 32'sd0) && (xf_reg[1] > dmin_reg)
                        && (xf_reg[1] < dmax_reg);
        side4_next.u_neg = ~(xf_reg[0][31] ^ fx_reg[31] ^ xf_reg[1][31]);
        side4_next.v_neg = xf_reg[2][31] ^ fy_reg[31] ^ xf_reg[1][31];
    end

    // stage 4: numerator products
    logic           st4_vld_reg;
    lpp_pkg::side_t st4_side_reg;
    logic [31:0]    atx_reg;
    logic [31:0]    atz_reg;
    logic [31:0]    afx_reg;
    logic [31:0]    afy_reg;
    logic [31:0]    ad4_reg;

    // stage 5: divider entry
    logic           st5_vld_reg;
    lpp_pkg::side_t st5_side_reg;
    logic [63:0]    nu_reg;
    logic [63:0]    nv_reg;
    logic [31:0]    ad5_reg;

    logic [lpp_pkg::DIV_QW-1:0] qu;
    logic [lpp_pkg::DIV_QW-1:0] qv;
    logic                       ovf_u;
    logic                       ovf_v;

    lpp_div u_div_u (
        .clk (clk),
        .en  (adv),
        .num (nu_reg),
        .den (ad5_reg),
        .quo (qu),
        .ovf (ovf_u)
    );

    lpp_div u_div_v (
        .clk (clk),
        .en  (adv),
        .num (nv_reg),
        .den (ad5_reg),
        .quo (qv),
        .ovf (ovf_v)
    );

    logic [lpp_pkg::DIV_LAT-1:0] dl_vld_reg;
    lpp_pkg::side_t              dl_reg [lpp_pkg::DIV_LAT];
    lpp_pkg::side_t              dl_last;

    assign dl_last = dl_reg[lpp_pkg::DIV_LAT-1];

    // stage 6: signed quotient plus centre
    logic               st6_vld_reg;
    lpp_pkg::item_t     st6_item_reg;
    logic               st6_ok_reg;
    logic signed [35:0] su_reg;
    logic signed [35:0] sv_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [3:0]         idx6;
    logic signed [35:0] qu36;
    logic signed [35:0] qv36;
    logic signed [35:0] su_next;
    logic signed [35:0] sv_next;

    assign idx6    = dl_last.item.py[3:0];
    assign qu36    = 36'(qu);
    assign qv36    = 36'(qv);
    assign su_next = (dl_last.u_neg ? -qu36 : qu36) + 36'(cx_reg);
    assign sv_next = (dl_last.v_neg ? -qv36 : qv36) + 36'(cy_reg);

    always_ff @(posedge clk)
    begin
        if (adv && dl_vld_reg[lpp_pkg::DIV_LAT-1]
            && dl_last.item.op == lpp_pkg::OP_CALIB)
        begin
            if (idx6 == lpp_pkg::CAL_CX)
            begin
                cx_reg <= dl_last.item.px;
            end
            if (idx6 == lpp_pkg::CAL_CY)
            begin
                cy_reg <= dl_last.item.px;
            end
        end
    end

    // stage 7: pixel range and map address
    logic                      st7_vld_reg;
    lpp_pkg::item_t            st7_item_reg;
    logic                      st7_hit_reg;
    logic [lpp_pkg::MAP_AW-1:0] st7_addr_reg;
    logic                      hit_next;
    logic [lpp_pkg::COL_W-1:0] col;
    logic [lpp_pkg::ROW_W-1:0] row;
    logic [lpp_pkg::MAP_AW-1:0] addr_next;

    assign hit_next = st6_ok_reg && (su_reg > PIX_LO) && (su_reg < U_HI)
                   && (sv_reg > PIX_LO) && (sv_reg < V_HI);
    assign col = su_reg[35] ? '0 : su_reg[16 +: lpp_pkg::COL_W];
    assign row = sv_reg[35] ? '0 : sv_reg[16 +: lpp_pkg::ROW_W];

    always_comb
    begin
        if (st6_item_reg.op == lpp_pkg::OP_LABEL)
        begin
            addr_next = st6_item_reg.px[lpp_pkg::MAP_AW-1:0];
        end
        else
        begin
            addr_next = lpp_pkg::MAP_AW'(32'(row) * 32'(lpp_pkg::IMG_W) + 32'(col));
        end
    end

    // stage 8: label map
    logic           st8_vld_reg;
    lpp_pkg::item_t st8_item_reg;
    logic           st8_hit_reg;
    logic [7:0]     map_rdata;

    lpp_ram #(
        .WIDTH (8),
        .DEPTH (lpp_pkg::MAP_DEPTH)
    ) u_label_map (
        .clk   (clk),
        .en    (adv),
        .we    (st7_vld_reg && st7_item_reg.op == lpp_pkg::OP_LABEL),
        .addr  (st7_addr_reg),
        .wdata (st7_item_reg.py[7:0]),
        .rdata (map_rdata)
    );

    // colour and emit
    logic [7:0] cls;
    logic [7:0] cls_eff;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic       emit;
    logic       out_vld_next;

    assign cls = st8_hit_reg ? map_rdata : lpp_pkg::LBL_NONE;

    always_comb
    begin
        red_next   = lpp_pkg::COLOR_FULL;
        green_next = lpp_pkg::COLOR_FULL;
        blue_next  = lpp_pkg::COLOR_FULL;
        cls_eff    = cls;
        case (cls)
            lpp_pkg::LBL_YELLOW: blue_next = '0;
            lpp_pkg::LBL_BLUE:
            begin
                red_next   = '0;
                green_next = '0;
            end
            lpp_pkg::LBL_RED:
            begin
                green_next = '0;
                blue_next  = '0;
            end
            default: cls_eff = lpp_pkg::LBL_NONE;
        endcase
        case (mode_reg)
            lpp_pkg::MODE_ALL:   emit = 1'b1;
            lpp_pkg::MODE_THREE: emit = cls_eff inside {[lpp_pkg::LBL_YELLOW:lpp_pkg::LBL_RED]};
            lpp_pkg::MODE_TWO:   emit = cls_eff inside {lpp_pkg::LBL_YELLOW, lpp_pkg::LBL_BLUE};
            default:             emit = 1'b0;
        endcase
    end

    assign out_vld_next = st8_vld_reg && st8_item_reg.op == lpp_pkg::OP_POINT && emit;

    logic [31:0] out_x_reg;
    logic [31:0] out_y_reg;
    logic [31:0] out_z_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
            st4_vld_reg <= 1'b0;
            st5_vld_reg <= 1'b0;
            dl_vld_reg  <= '0;
            st6_vld_reg <= 1'b0;
            st7_vld_reg <= 1'b0;
            st8_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            st1_vld_reg <= acc && in_item_next.op != lpp_pkg::OP_NONE;
            st2_vld_reg <= st1_vld_reg;
            st3_vld_reg <= st2_vld_reg;
            st4_vld_reg <= st3_vld_reg;
            st5_vld_reg <= st4_vld_reg;
            dl_vld_reg  <= {dl_vld_reg[lpp_pkg::DIV_LAT-2:0], st5_vld_reg};
            st6_vld_reg <= dl_vld_reg[lpp_pkg::DIV_LAT-1];
            st7_vld_reg <= st6_vld_reg;
            st8_vld_reg <= st7_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_item_reg <= in_item_next;

            st2_item_reg <= st1_item_reg;
            prod_reg     <= prod_next;
            trans_reg    <= trans_next;

            st3_item_reg <= st2_item_reg;
            xf_reg       <= xf_next;

            st4_side_reg <= side4_next;
            atx_reg      <= lpp_pkg::abs32(xf_reg[0]);
            atz_reg      <= lpp_pkg::abs32(xf_reg[2]);
            ad4_reg      <= lpp_pkg::abs32(xf_reg[1]);
            afx_reg      <= lpp_pkg::abs32(fx_reg);
            afy_reg      <= lpp_pkg::abs32(fy_reg);

            st5_side_reg <= st4_side_reg;
            nu_reg       <= 64'(atx_reg) * 64'(afx_reg);
            nv_reg       <= 64'(atz_reg) * 64'(afy_reg);
            ad5_reg      <= ad4_reg;

            dl_reg[0] <= st5_side_reg;
            for (int k = 1; k < lpp_pkg::DIV_LAT; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end

            st6_item_reg <= dl_last.item;
            st6_ok_reg   <= dl_last.dok && !ovf_u && !ovf_v;
            su_reg       <= su_next;
            sv_reg       <= sv_next;

            st7_item_reg <= st6_item_reg;
            st7_hit_reg  <= hit_next;
            st7_addr_reg <= addr_next;

            st8_item_reg <= st7_item_reg;
            st8_hit_reg  <= st7_hit_reg;

            out_x_reg <= st8_item_reg.px;
            out_y_reg <= st8_item_reg.py;
            out_z_reg <= st8_item_reg.pz;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign item_out.valid = out_vld_reg;
    assign item_out.out_x = out_x_reg;
    assign item_out.out_y = out_y_reg;
    assign item_out.out_z = out_z_reg;
    assign item_out.red   = red_reg;
    assign item_out.green = green_reg;
    assign item_out.blue  = blue_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dl_vld_reg) && $stable(st8_vld_reg) && $stable(st1_vld_reg))
        else $error("pipeline moved while stalled");

    a_mode_off: assert property (@(posedge clk) disable iff (!rst_n)
        adv && mode_reg == lpp_pkg::MODE_OFF |=> !out_vld_reg)
        else $error("item emitted with output disabled");

    a_filtered_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && mode_reg != lpp_pkg::MODE_ALL
        |-> !(red_reg == lpp_pkg::COLOR_FULL && green_reg == lpp_pkg::COLOR_FULL
              && blue_reg == lpp_pkg::COLOR_FULL))
        else $error("unlabelled item emitted in filtered mode");

    a_from_point: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(st8_vld_reg && st8_item_reg.op == lpp_pkg::OP_POINT))
        else $error("result without a point item");

endmodule

>>> tb/lpp_checker.sv
// Result checker for the lidar point label projector.
// Watches both item channels and the APB writes, predicts each result, compares.
// Depends on lpp_pkg and lpp_stream_if.
`timescale 1ns / 1ps

module lpp_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    lpp_in_if                          in_ch,
    lpp_out_if                         out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
    } colored_point_t;

    logic [7:0]         label_map [0:lpp_pkg::MAP_DEPTH-1];
    logic signed [31:0] calib [0:15];
    logic [30:0]        lateral;
    logic signed [31:0] fwd_min;
    logic signed [31:0] fwd_max;
    logic signed [31:0] dep_min;
    logic signed [31:0] dep_max;
    logic [1:0]         mode;
    colored_point_t     colored_q [$];

    assign pending_count = colored_q.size();

    function automatic longint xform_row(int r, longint x, longint y, longint z);
        longint s;
        s = ((longint'(calib[r*4]) * x) >>> 16) + ((longint'(calib[r*4+1]) * y) >>> 16)
            + ((longint'(calib[r*4+2]) * z) >>> 16) + longint'(calib[r*4+3]);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s;
    endfunction

    function automatic bit color_point(input logic signed [31:0] px, py, pz,
                                       output colored_point_t res);
        longint tx, d, tz, u, v, col, row;
        logic [7:0] lbl;
        bit hit;
        bit emit;
        lbl = lpp_pkg::LBL_NONE;
        hit = 0;
        if (longint'(py) < -longint'(lateral) || longint'(py) > longint'(lateral))
            return 0;
        if (px < fwd_min || px > fwd_max)
            return 0;
        tx = xform_row(0, px, py, pz);
        d  = xform_row(1, px, py, pz);
        tz = xform_row(2, px, py, pz);
        if (d != 0 && d > longint'(dep_min) && d < longint'(dep_max))
        begin
            u = (-tx * longint'(calib[lpp_pkg::CAL_FX])) / d;
            v = (tz * longint'(calib[lpp_pkg::CAL_FY])) / d;
            col = (u + longint'(calib[lpp_pkg::CAL_CX])) / 65536;
            row = (v + longint'(calib[lpp_pkg::CAL_CY])) / 65536;
            if (col >= 0 && col < lpp_pkg::IMG_W && row >= 0 && row < lpp_pkg::IMG_H)
            begin
                lbl = label_map[row * lpp_pkg::IMG_W + col];
                hit = 1;
            end
        end
        res.x = px;
        res.y = py;
        res.z = pz;
        res.r = lpp_pkg::COLOR_FULL;
        res.g = lpp_pkg::COLOR_FULL;
        res.b = lpp_pkg::COLOR_FULL;
        if (hit && lbl == lpp_pkg::LBL_YELLOW)
            res.b = 8'd0;
        else if (hit && lbl == lpp_pkg::LBL_BLUE)
        begin
            res.r = 8'd0;
            res.g = 8'd0;
        end
        else if (hit && lbl == lpp_pkg::LBL_RED)
        begin
            res.g = 8'd0;
            res.b = 8'd0;
        end
        else
            lbl = lpp_pkg::LBL_NONE;
        case (mode)
            lpp_pkg::MODE_ALL:   emit = 1;
            lpp_pkg::MODE_THREE: emit = (lbl == lpp_pkg::LBL_YELLOW || lbl == lpp_pkg::LBL_BLUE
                                         || lbl == lpp_pkg::LBL_RED);
            lpp_pkg::MODE_TWO:   emit = (lbl == lpp_pkg::LBL_YELLOW || lbl == lpp_pkg::LBL_BLUE);
            default:             emit = 0;
        endcase
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        colored_point_t res;
        colored_point_t want;
        if (!rst_n)
        begin
            lateral = lpp_pkg::LATERAL_RST;
            fwd_min = lpp_pkg::FWD_MIN_RST;
            fwd_max = lpp_pkg::FWD_MAX_RST;
            dep_min = lpp_pkg::DEP_MIN_RST;
            dep_max = lpp_pkg::DEP_MAX_RST;
            mode    = lpp_pkg::MODE_ALL;
            fail_count = 0;
            colored_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[lpp_pkg::CFG_AW-1:2])
                    lpp_pkg::REG_LATERAL: lateral = pwdata[30:0];
                    lpp_pkg::REG_FWD_MIN: fwd_min = pwdata;
                    lpp_pkg::REG_FWD_MAX: fwd_max = pwdata;
                    lpp_pkg::REG_DEP_MIN: dep_min = pwdata;
                    lpp_pkg::REG_DEP_MAX: dep_max = pwdata;
                    lpp_pkg::REG_MODE:    mode    = pwdata[1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.req_type)
                    lpp_pkg::REQ_LABEL:
                        label_map[in_ch.pixel_row * lpp_pkg::IMG_W + in_ch.pixel_col] =
                            in_ch.label_value;
                    lpp_pkg::REQ_CALIB: calib[in_ch.calib_index] = in_ch.calib_value;
                    lpp_pkg::REQ_POINT:
                        if (color_point(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, res))
                            colored_q.insert(colored_q.size(), res);
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (colored_q.size() == 0)
                begin
                    $error("unexpected result item x=%0d y=%0d", out_ch.out_x, out_ch.out_y);
                    fail_count++;
                end
                else
                begin
                    want = colored_q.pop_front();
                    if (out_ch.out_x !== want.x)
                    begin
                        $error("out_x expected %0d actual %0d", want.x, out_ch.out_x);
                        fail_count++;
                    end
                    if (out_ch.out_y !== want.y)
                    begin
                        $error("out_y expected %0d actual %0d", want.y, out_ch.out_y);
                        fail_count++;
                    end
                    if (out_ch.out_z !== want.z)
                    begin
                        $error("out_z expected %0d actual %0d", want.z, out_ch.out_z);
                        fail_count++;
                    end
                    if (out_ch.red !== want.r)
                    begin
                        $error("red expected %0d actual %0d", want.r, out_ch.red);
                        fail_count++;
                    end
                    if (out_ch.green !== want.g)
                    begin
                        $error("green expected %0d actual %0d", want.g, out_ch.green);
                        fail_count++;
                    end
                    if (out_ch.blue !== want.b)
                    begin
                        $error("blue expected %0d actual %0d", want.b, out_ch.blue);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the lidar point label projector testbench: clock, reset, stimulus, verdict.
// Drives items and APB writes; lpp_checker predicts and compares the results.
// Depends on lpp_pkg, lpp_stream_if, lpp_checker and lidar_point_label_projector.
`timescale 1ns / 1ps

module testbench;

    localparam int N_RANDOM   = 1200;
    localparam int N_SETTINGS = 8;
    localparam int DRAIN      = 60;
    localparam int STALL_MAX  = 4000;
    localparam longint ONE    = 65536;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lpp_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    int                         fail_count;
    int                         pending_count;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         stall_cycles;
    longint                     cfg_tab [N_SETTINGS][6];
    logic signed [31:0]         cal_copy [16];
    bit                         lbl_written [lpp_pkg::MAP_DEPTH];

    lpp_in_if  item_in ();
    lpp_out_if item_out ();

    lidar_point_label_projector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (item_in),
        .item_out (item_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lpp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (item_in),
        .out_ch        (item_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        item_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if ((item_in.valid && item_in.ready) || (item_out.valid && item_out.ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_range(longint lo, longint hi);
        longint t;
        longint unsigned span;
        if (lo < -64'sd2147483648) lo = -64'sd2147483648;
        if (hi > 64'sd2147483647)  hi = 64'sd2147483647;
        if (hi < lo)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        span = longint'(hi - lo + 1);
        return 32'(lo + longint'({$urandom, $urandom} % span));
    endfunction

    function automatic longint mirror_row(int r, longint x, longint y, longint z);
        longint s;
        s = ((longint'(cal_copy[r*4]) * x) >>> 16) + ((longint'(cal_copy[r*4+1]) * y) >>> 16)
            + ((longint'(cal_copy[r*4+2]) * z) >>> 16) + longint'(cal_copy[r*4+3]);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s;
    endfunction

    // map address a point may read under the calibration sent so far
    function automatic bit pixel_hit(input logic signed [31:0] x, y, z, output int addr);
        longint tx, d, tz, u, v, col, row;
        addr = 0;
        tx = mirror_row(0, x, y, z);
        d  = mirror_row(1, x, y, z);
        tz = mirror_row(2, x, y, z);
        if (d == 0)
            return 0;
        u = (-tx * longint'(cal_copy[lpp_pkg::CAL_FX])) / d;
        v = (tz * longint'(cal_copy[lpp_pkg::CAL_FY])) / d;
        col = (u + longint'(cal_copy[lpp_pkg::CAL_CX])) / 65536;
        row = (v + longint'(cal_copy[lpp_pkg::CAL_CY])) / 65536;
        if (col < 0 || col >= lpp_pkg::IMG_W || row < 0 || row >= lpp_pkg::IMG_H)
            return 0;
        addr = int'(row * lpp_pkg::IMG_W + col);
        return 1;
    endfunction

    task automatic send_item(logic [1:0] rt, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [9:0] col, logic [8:0] row, logic [7:0] lv,
                             logic [3:0] ci, logic [31:0] cv);
        if (rt == lpp_pkg::REQ_LABEL)
            lbl_written[int'(row) * lpp_pkg::IMG_W + int'(col)] = 1'b1;
        else if (rt == lpp_pkg::REQ_CALIB)
            cal_copy[ci] = cv;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_in.valid <= 1'b0;
            @(posedge clk);
        end
        item_in.valid       <= 1'b1;
        item_in.req_type    <= rt;
        item_in.pos_x       <= x;
        item_in.pos_y       <= y;
        item_in.pos_z       <= z;
        item_in.pixel_col   <= col;
        item_in.pixel_row   <= row;
        item_in.label_value <= lv;
        item_in.calib_index <= ci;
        item_in.calib_value <= cv;
        do
            @(posedge clk);
        while (!item_in.ready);
    endtask

    // label the pixel first when the point could land on one never written
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int addr;
        if (pixel_hit(x, y, z, addr) && !lbl_written[addr])
            send_item(lpp_pkg::REQ_LABEL, $urandom, $urandom, $urandom,
                      10'(addr % lpp_pkg::IMG_W), 9'(addr / lpp_pkg::IMG_W),
                      8'($urandom_range(0, 5)), 4'($urandom), $urandom);
        send_item(lpp_pkg::REQ_POINT, x, y, z, 10'($urandom), 9'($urandom), 8'($urandom),
                  4'($urandom), $urandom);
    endtask

    task automatic send_calib(logic [3:0] ci, logic [31:0] cv);
        send_item(lpp_pkg::REQ_CALIB, $urandom, $urandom, $urandom, 10'($urandom),
                  9'($urandom), 8'($urandom), ci, cv);
    endtask

    task automatic load_nominal_calib();
        logic [31:0] words [16];
        foreach (words[i])
            words[i] = 32'd0;
        words[1]               = 32'(-ONE);
        words[4]               = 32'(ONE);
        words[10]              = 32'(ONE);
        words[lpp_pkg::CAL_FX] = 32'(200 * ONE);
        words[lpp_pkg::CAL_FY] = 32'(200 * ONE);
        words[lpp_pkg::CAL_CX] = 32'(512 * ONE);
        words[lpp_pkg::CAL_CY] = 32'(256 * ONE);
        for (int i = 0; i < 16; i++)
            send_calib(4'(i), words[i]);
    endtask

    task automatic settle();
        item_in.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lpp_pkg::CFG_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(int s);
        apb_write(lpp_pkg::REG_LATERAL, 32'(cfg_tab[s][0]));
        apb_write(lpp_pkg::REG_FWD_MIN, 32'(cfg_tab[s][1]));
        apb_write(lpp_pkg::REG_FWD_MAX, 32'(cfg_tab[s][2]));
        apb_write(lpp_pkg::REG_DEP_MIN, 32'(cfg_tab[s][3]));
        apb_write(lpp_pkg::REG_DEP_MAX, 32'(cfg_tab[s][4]));
        apb_write(lpp_pkg::REG_MODE,    32'(cfg_tab[s][5]));
    endtask

    task automatic random_item(int s);
        int          r;
        longint      lim;
        logic [31:0] x, y, z;
        logic [1:0]  rt;
        lim = cfg_tab[s][0];
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            if ($urandom_range(0, 4) == 0)
                x = 32'(cfg_tab[s][$urandom_range(1, 2)] + $urandom_range(0, 2) - 1);
            else
                x = pick_range(cfg_tab[s][1] - ONE, cfg_tab[s][2] + ONE);
            if ($urandom_range(0, 4) == 0)
                y = 32'(($urandom_range(0, 1) ? lim : -lim) + $urandom_range(0, 2) - 1);
            else
                y = pick_range(-lim - ONE, lim + ONE);
            z = pick_range(-8 * ONE, 8 * ONE);
            send_point(x, y, z);
        end
        else if (r < 83)
        begin
            rt = 2'($urandom_range(0, 3));
            if (rt == lpp_pkg::REQ_POINT)
                send_point($urandom, $urandom, $urandom);
            else
                send_item(rt, $urandom, $urandom, $urandom, 10'($urandom), 9'($urandom),
                          8'($urandom), 4'($urandom), $urandom);
        end
        else if (r < 93)
            send_item(lpp_pkg::REQ_LABEL, $urandom, $urandom, $urandom, 10'($urandom),
                      9'($urandom), 8'($urandom_range(0, 5)), 4'($urandom), $urandom);
        else if (r < 98)
            send_calib(4'($urandom), $urandom_range(0, 1) ? $urandom
                       : pick_range(-2 * ONE, 2 * ONE));
        else
            send_item(2'd3, $urandom, $urandom, $urandom, 10'($urandom), 9'($urandom),
                      8'($urandom), 4'($urandom), $urandom);
    endtask

    initial
    begin
        int done;
        int per_phase;
        cfg_tab[0] = '{655360, 0, 1966080, 0, 1966080, lpp_pkg::MODE_ALL};
        cfg_tab[1] = '{655360, 0, 1966080, 0, 1966080, lpp_pkg::MODE_THREE};
        cfg_tab[2] = '{655360, 0, 1966080, 0, 1966080, lpp_pkg::MODE_TWO};
        cfg_tab[3] = '{2147483647, -64'sd2147483648, 2147483647, -64'sd2147483648,
                       2147483647, lpp_pkg::MODE_ALL};
        cfg_tab[4] = '{0, 5 * ONE, 5 * ONE, 2 * ONE, 8 * ONE, lpp_pkg::MODE_ALL};
        cfg_tab[5] = '{3 * ONE, 10 * ONE, 5 * ONE, 0, 1966080, lpp_pkg::MODE_ALL};
        cfg_tab[6] = '{1310720, -5 * ONE, 40 * ONE, -3 * ONE, 20 * ONE, lpp_pkg::MODE_THREE};
        cfg_tab[7] = '{655360, 0, 1966080, 0, 1966080, lpp_pkg::MODE_OFF};

        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        item_in.valid       <= 1'b0;
        item_in.req_type    <= lpp_pkg::REQ_POINT;
        item_in.pos_x       <= '0;
        item_in.pos_y       <= '0;
        item_in.pos_z       <= '0;
        item_in.pixel_col   <= '0;
        item_in.pixel_row   <= '0;
        item_in.label_value <= '0;
        item_in.calib_index <= '0;
        item_in.calib_value <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(0);
        load_nominal_calib();

        send_idle_pct = 28;
        recv_idle_pct = 60;
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'(10 * ONE), 32'd0, 32'd0);
        send_point(32'(5 * ONE), 32'd655360, 32'(ONE));
        send_point(32'(5 * ONE), -32'd655360, -32'(ONE));
        send_point(32'(5 * ONE), 32'd655361, 32'd0);
        send_point(32'(5 * ONE), -32'd655361, 32'd0);
        send_point(32'd1966080, 32'd0, 32'd0);
        send_point(32'd1966081, 32'd0, 32'd0);
        send_point(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'(10 * ONE), 32'd0, 32'h7FFF_FFFF);
        send_point(32'(10 * ONE), 32'd0, 32'h8000_0000);
        send_item(lpp_pkg::REQ_LABEL, '0, '0, '0, 10'd1023, 9'd511, 8'd255, '0, '0);
        send_item(lpp_pkg::REQ_LABEL, '0, '0, '0, 10'd0, 9'd0, lpp_pkg::LBL_YELLOW, '0, '0);
        send_item(2'd3, '1, '1, '1, '1, '1, '1, '1, '1);
        send_calib(lpp_pkg::CAL_CX, 32'h7FFF_FFFF);
        send_point(32'(10 * ONE), 32'd0, 32'd0);
        send_calib(lpp_pkg::CAL_CX, 32'h8000_0000);
        send_point(32'(10 * ONE), 32'd0, 32'd0);
        send_calib(4'd3, 32'h7FFF_FFFF);
        send_point(32'(10 * ONE), 32'(ONE), 32'd0);
        send_calib(4'd3, 32'h8000_0000);
        send_point(32'(10 * ONE), -32'(ONE), 32'd0);

        done = 0;
        per_phase = N_RANDOM / N_SETTINGS;
        for (int s = 0; s < N_SETTINGS; s++)
        begin
            settle();
            apply_setting(s);
            load_nominal_calib();
            for (int i = 0; i < per_phase; i++)
            begin
                if (done < N_RANDOM / 3)
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 60;
                end
                else if (done < 2 * N_RANDOM / 3)
                begin
                    send_idle_pct = 60;
                    recv_idle_pct = 28;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_item(s);
                done++;
            end
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
